FILE: rtl/lzc_pkg.sv
package lzc_pkg;

  localparam int MAX_LEN     = 1024;
  localparam int SYMBOL_BITS = 16;

  // field widths of the item ports
  localparam int SYM_W   = 16;
  localparam int CC_W    = 11;
  localparam int RATIO_W = 17;
  localparam int LEN_W   = 11;

  localparam int FRAC_BITS = 16;
  localparam int ADDR_W    = $clog2(MAX_LEN);
  localparam int CNT_W     = $clog2(MAX_LEN + 1);
  // pointers and skip targets may run past n, up to about 2n
  localparam int PTR_W     = CNT_W + 1;
  localparam int DIV_W     = CNT_W + FRAC_BITS;
  localparam int STEP_W    = $clog2(DIV_W + 1);

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } lzc_div_req_t;

endpackage

FILE: rtl/lzc_store.sv
module lzc_store import lzc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [ADDR_W-1:0]      waddr_i,
  input  logic [SYMBOL_BITS-1:0] wdata_i,
  input  logic [ADDR_W-1:0]      raddr_a_i,
  input  logic [ADDR_W-1:0]      raddr_b_i,
  output logic [SYMBOL_BITS-1:0] rdata_a_o,
  output logic [SYMBOL_BITS-1:0] rdata_b_o
);

  logic [SYMBOL_BITS-1:0] mem_q [MAX_LEN];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

FILE: rtl/lzc_div.sv
module lzc_div import lzc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lzc_div_req_t     req_i,
  output logic             busy_o,
  output logic [DIV_W-1:0] quot_o
);

  logic [STEP_W-1:0] step_q, step_d;
  logic [DIV_W-1:0]  dvd_q, dvd_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  dvs_q, dvs_d;
  logic              busy_q, busy_d;
  logic [CNT_W:0]    rem_sh;
  logic              ge;

  // restoring division, one quotient bit a cycle shifted into the dividend
  assign rem_sh = {rem_q, dvd_q[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    step_d = step_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    busy_d = busy_q;
    if (req_i.start) begin
      step_d = '0;
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d  = {dvd_q[DIV_W-2:0], ge};
      rem_d  = ge ? CNT_W'(rem_sh - {1'b0, dvs_q}) : CNT_W'(rem_sh);
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = dvd_q;

endmodule

FILE: rtl/lz76_complexity_count.sv
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_ready_o    symbol_i, last_i
// out       output     out_valid_o / out_ready_i  component_count_o, ratio_o, length_o,
//                                                 overflow_o
//
// in_ready_o stays high while loading, so items may come back to back; items beyond the store are dropped and flagged
// after the last item the parse alternates ST_CHK (two-port store read) and ST_CMP
// (compare and pointer update) for each symbol comparison, then the divider forms the
// ratio, and the result is registered once the output register is free
// in_ready_o is low from the last item until the result is in the output register
// a result waiting on out_ready_i does not stop the next sequence from loading
// reset is asynchronous, active low; the store needs no clearing
module lz76_complexity_count import lzc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SYM_W-1:0]   symbol_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CC_W-1:0]    component_count_o,
  output logic [RATIO_W-1:0] ratio_o,
  output logic [LEN_W-1:0]   length_o,
  output logic               overflow_o
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CHK,
    ST_CMP,
    ST_DIV
  } state_e;

  state_e state_q;

  logic [CNT_W-1:0] fill_q;
  logic             ovf_q;
  logic [CNT_W-1:0] n_q;
  logic             res_ovf_q;
  logic [CNT_W-1:0] c_q;
  logic [PTR_W-1:0] a_q, b_q, k_q, kmax_q;

  logic               out_valid_q;
  logic [CC_W-1:0]    cc_q;
  logic [RATIO_W-1:0] ratio_q;
  logic [LEN_W-1:0]   len_q;
  logic               out_ovf_q;

  logic                   accept;
  logic                   store_we;
  logic [CNT_W-1:0]       fill_inc;
  logic [PTR_W:0]         bk_sum;
  logic                   more;
  logic [PTR_W-1:0]       addr_a, addr_b;
  logic [SYMBOL_BITS-1:0] rd_a, rd_b;
  logic [PTR_W-1:0]       kmax_new, a_inc;
  logic                   slot_free;
  logic                   res_load;
  logic                   div_busy;
  logic [DIV_W-1:0]       quot;
  lzc_div_req_t           div_req;

  assign in_ready_o = (state_q == ST_LOAD);
  assign accept     = in_valid_i && in_ready_o;
  assign store_we   = accept && (fill_q < CNT_W'(MAX_LEN));
  assign fill_inc   = store_we ? fill_q + CNT_W'(1) : fill_q;

  assign bk_sum = {1'b0, b_q} + {1'b0, k_q};
  assign more   = bk_sum < (PTR_W + 1)'(n_q);
  assign addr_a = a_q + k_q;
  assign addr_b = PTR_W'(bk_sum);

  assign kmax_new  = (k_q > kmax_q) ? k_q : kmax_q;
  assign a_inc     = a_q + PTR_W'(1);
  assign slot_free = !out_valid_q || out_ready_i;
  assign res_load  = (state_q == ST_DIV) && !div_busy && slot_free;

  assign div_req.start    = (state_q == ST_CHK) && !more;
  assign div_req.dividend = {c_q, FRAC_BITS'(0)};
  assign div_req.divisor  = n_q;

  lzc_store u_store (
    .clk_i     (clk_i),
    .we_i      (store_we),
    .waddr_i   (fill_q[ADDR_W-1:0]),
    .wdata_i   (symbol_i[SYMBOL_BITS-1:0]),
    .raddr_a_i (addr_a[ADDR_W-1:0]),
    .raddr_b_i (addr_b[ADDR_W-1:0]),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  lzc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .quot_o (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      res_ovf_q   <= 1'b0;
      c_q         <= '0;
      a_q         <= '0;
      b_q         <= '0;
      k_q         <= '0;
      kmax_q      <= '0;
      cc_q        <= '0;
      ratio_q     <= '0;
      len_q       <= '0;
      out_ovf_q   <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_LOAD: begin
          if (accept) begin
            if (last_i) begin
              n_q       <= fill_inc;
              res_ovf_q <= ovf_q || !store_we;
              fill_q    <= '0;
              ovf_q     <= 1'b0;
              c_q       <= CNT_W'(1);
              a_q       <= '0;
              b_q       <= PTR_W'(1);
              k_q       <= '0;
              kmax_q    <= '0;
              state_q   <= ST_CHK;
            end else begin
              fill_q <= fill_inc;
              if (!store_we) begin
                ovf_q <= 1'b1;
              end
            end
          end
        end
        ST_CHK: begin
          state_q <= more ? ST_CMP : ST_DIV;
        end
        ST_CMP: begin
          state_q <= ST_CHK;
          if (rd_a == rd_b) begin
            k_q <= k_q + PTR_W'(1);
          end else if (a_inc != b_q) begin
            a_q    <= a_inc;
            k_q    <= '0;
            kmax_q <= kmax_new;
          end else begin
            // new component: skip past the longest match seen
            c_q    <= c_q + CNT_W'(1);
            b_q    <= b_q + kmax_new + PTR_W'(1);
            a_q    <= '0;
            k_q    <= '0;
            kmax_q <= '0;
          end
        end
        ST_DIV: begin
          if (res_load) begin
            cc_q      <= CC_W'(c_q);
            ratio_q   <= RATIO_W'(quot);
            len_q     <= LEN_W'(n_q);
            out_ovf_q <= res_ovf_q;
            state_q   <= ST_LOAD;
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign component_count_o = cc_q;
  assign ratio_o           = ratio_q;
  assign length_o          = len_q;
  assign overflow_o        = out_ovf_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(MAX_LEN))
    else $error("fill count beyond store size");

  a_ptr_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHK) |-> (a_q < b_q))
    else $error("parse pointer a reached b");

  a_count_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (component_count_o <= length_o && component_count_o != '0))
    else $error("component count outside 1..length");

  a_ratio_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ratio_o <= RATIO_W'(65536)))
    else $error("ratio above one");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule
